FILE: src/qlu_pkg.sv
`timescale 1ns / 1ps

package qlu_pkg;

	// Results per input byte and the widths that fit it
	localparam int MAX_RESULTS = 4;
	localparam int CNT_W       = 3;
	localparam int IDX_W       = 2;

	// Error codes
	localparam logic [2:0] ERR_NONE      = 3'd0;
	localparam logic [2:0] ERR_QUOTE     = 3'd1;
	localparam logic [2:0] ERR_ESCAPE    = 3'd2;
	localparam logic [2:0] ERR_HEX       = 3'd3;
	localparam logic [2:0] ERR_TRUNCATED = 3'd4;
	localparam logic [2:0] ERR_RANGE     = 3'd5;

	// Characters with a special meaning
	localparam logic [7:0] CH_AT  = 8'h40;
	localparam logic [7:0] CH_BSL = 8'h5C;
	localparam logic [7:0] CH_DQ  = 8'h22;
	localparam logic [7:0] CH_SQ  = 8'h27;
	localparam logic [7:0] CH_BQ  = 8'h60;
	localparam logic [7:0] CH_N   = 8'h6E;
	localparam logic [7:0] CH_R   = 8'h72;
	localparam logic [7:0] CH_T   = 8'h74;
	localparam logic [7:0] CH_B   = 8'h62;
	localparam logic [7:0] CH_F   = 8'h66;
	localparam logic [7:0] CH_LU  = 8'h75;
	localparam logic [7:0] CH_UU  = 8'h55;

	localparam logic [7:0] BYTE_LF  = 8'h0A;
	localparam logic [7:0] BYTE_CR  = 8'h0D;
	localparam logic [7:0] BYTE_TAB = 8'h09;
	localparam logic [7:0] BYTE_BS  = 8'h08;
	localparam logic [7:0] BYTE_FF  = 8'h0C;

	localparam logic [23:0] CP_MAX = 24'h10FFFF;
	localparam logic [20:0] CP_1B  = 21'h80;
	localparam logic [20:0] CP_2B  = 21'h800;
	localparam logic [20:0] CP_3B  = 21'h10000;

	typedef enum logic [1:0] {
		PH_NORMAL,
		PH_QUOTE,
		PH_ESC,
		PH_HEX
	} qlu_phase_t;

	// One result item
	typedef struct packed {
		logic [7:0] data;
		logic       valid;
		logic       fin;
		logic [2:0] err;
	} qlu_item_t;

	// All results caused by one input byte
	typedef struct packed {
		logic [CNT_W-1:0]                 cnt;
		qlu_item_t [MAX_RESULTS-1:0]      item;
	} qlu_bundle_t;

	localparam qlu_item_t ITEM_END = '{data: 8'h00, valid: 1'b0, fin: 1'b1, err: ERR_NONE};

	function automatic qlu_item_t mk_data(input logic [7:0] b);
		qlu_item_t it;
		it = '{data: b, valid: 1'b1, fin: 1'b0, err: ERR_NONE};
		return it;
	endfunction

	function automatic qlu_item_t mk_err(input logic [2:0] e);
		qlu_item_t it;
		it = '{data: 8'h00, valid: 1'b0, fin: 1'b0, err: e};
		return it;
	endfunction

	// Encode a code point as UTF-8; zero gives no bytes
	function automatic qlu_bundle_t utf8_encode(input logic [20:0] cp);
		qlu_bundle_t bd;
		bd = '0;
		if (cp == 21'd0) begin
			bd.cnt = CNT_W'(0);
		end else if (cp < CP_1B) begin
			bd.cnt     = CNT_W'(1);
			bd.item[0] = mk_data({1'b0, cp[6:0]});
		end else if (cp < CP_2B) begin
			bd.cnt     = CNT_W'(2);
			bd.item[0] = mk_data({3'b110, cp[10:6]});
			bd.item[1] = mk_data({2'b10, cp[5:0]});
		end else if (cp < CP_3B) begin
			bd.cnt     = CNT_W'(3);
			bd.item[0] = mk_data({4'b1110, cp[15:12]});
			bd.item[1] = mk_data({2'b10, cp[11:6]});
			bd.item[2] = mk_data({2'b10, cp[5:0]});
		end else begin
			bd.cnt     = CNT_W'(4);
			bd.item[0] = mk_data({5'b11110, cp[20:18]});
			bd.item[1] = mk_data({2'b10, cp[17:12]});
			bd.item[2] = mk_data({2'b10, cp[11:6]});
			bd.item[3] = mk_data({2'b10, cp[5:0]});
		end
		return bd;
	endfunction

endpackage

FILE: src/quoted_literal_unescaper.sv
`timescale 1ns / 1ps

// Quoted literal unescaper. Bytes of a quoted literal enter through push/full,
// one per cycle, marked first (quote or '@') and last; unescaped bytes, error
// items and a closing end item leave through empty/pop, one result per cycle
// while pop is high, with run_last on the final result caused by each input
// byte. An input byte is accepted every cycle while full is low. Each byte
// causes zero to four results; the output side drains them in order, so a byte
// that expands to N results (a \u or \U escape gives up to four UTF-8 bytes)
// holds the output side until all N are taken, and full rises only when DEPTH
// bundles of results are waiting. With nothing waiting ahead of it, the first
// result of a byte goes through the bundle queue and then the output register.
// Results never arrive out of order, and stalls on either side are absorbed by
// the bundle queue between the parser and the output stage.
module quoted_literal_unescaper #(
	parameter int DEPTH = 4
) (
	input  logic       clk,
	input  logic       arst_n,
	input  logic       push,
	output logic       full,
	input  logic [7:0] in_byte,
	input  logic       first_of_string,
	input  logic       last_of_string,
	output logic       empty,
	input  logic       pop,
	output logic [7:0] out_byte,
	output logic       byte_valid,
	output logic       run_last,
	output logic       string_end,
	output logic [2:0] error_code
);
	import qlu_pkg::*;

	logic        accept;
	logic        wr_en;
	logic        rd_en;
	logic        q_empty;
	qlu_bundle_t bnd;
	qlu_bundle_t head;

	// Accept a request whenever the queue has room
	assign accept = push && !full;
	assign wr_en  = accept && (bnd.cnt != CNT_W'(0));

	qlu_front u_front (
		.clk             (clk),
		.arst_n          (arst_n),
		.accept          (accept),
		.in_byte         (in_byte),
		.first_of_string (first_of_string),
		.last_of_string  (last_of_string),
		.bnd             (bnd)
	);

	qlu_queue #(
		.DEPTH (DEPTH)
	) u_queue (
		.clk     (clk),
		.arst_n  (arst_n),
		.wr_en   (wr_en),
		.wr_data (bnd),
		.q_full  (full),
		.rd_en   (rd_en),
		.rd_data (head),
		.q_empty (q_empty)
	);

	qlu_back u_back (
		.clk        (clk),
		.arst_n     (arst_n),
		.head       (head),
		.q_empty    (q_empty),
		.rd_en      (rd_en),
		.pop        (pop),
		.empty      (empty),
		.out_byte   (out_byte),
		.byte_valid (byte_valid),
		.run_last   (run_last),
		.string_end (string_end),
		.error_code (error_code)
	);

endmodule

FILE: src/qlu_front.sv
`timescale 1ns / 1ps

module qlu_front (
	input  logic                clk,
	input  logic                arst_n,
	input  logic                accept,
	input  logic [7:0]          in_byte,
	input  logic                first_of_string,
	input  logic                last_of_string,
	output qlu_pkg::qlu_bundle_t bnd
);
	import qlu_pkg::*;

	logic [7:0]  quote_q, quote_n;
	logic        raw_q, raw_n;
	logic        skip_q, skip_n;
	qlu_phase_t  phase_q, phase_n;
	logic [2:0]  left_q, left_n;
	logic [23:0] acc_q, acc_n;
	logic        bad_q, bad_n;

	logic        hex_ok;
	logic [3:0]  hex_d;
	logic [23:0] acc_shift;
	logic [2:0]  left_dec;
	logic        bad_upd;

	// Decode a hex digit
	always_comb begin
		hex_ok = 1'b1;
		hex_d  = 4'd0;
		if (in_byte inside {[8'h30:8'h39]}) begin
			hex_d = in_byte[3:0];
		end else if (in_byte inside {[8'h41:8'h46], [8'h61:8'h66]}) begin
			hex_d = in_byte[3:0] + 4'd9;
		end else begin
			hex_ok = 1'b0;
		end
	end

	assign acc_shift = hex_ok ? {acc_q[19:0], hex_d} : acc_q;
	assign left_dec  = left_q - 3'd1;
	assign bad_upd   = bad_q | ~hex_ok;

	// Classify the byte, build its results and the next state
	always_comb begin
		quote_n = quote_q;
		raw_n   = raw_q;
		skip_n  = skip_q;
		phase_n = phase_q;
		left_n  = left_q;
		acc_n   = acc_q;
		bad_n   = bad_q;
		bnd     = '0;
		if (first_of_string) begin
			phase_n = PH_NORMAL;
			left_n  = 3'd0;
			acc_n   = 24'd0;
			bad_n   = 1'b0;
			if (last_of_string) begin
				quote_n     = 8'h00;
				raw_n       = 1'b0;
				skip_n      = 1'b0;
				bnd.cnt     = CNT_W'(1);
				bnd.item[0] = ITEM_END;
			end else begin
				quote_n = in_byte;
				raw_n   = (in_byte == CH_AT);
				skip_n  = (in_byte == CH_AT);
			end
		end else if (last_of_string) begin
			quote_n = 8'h00;
			raw_n   = 1'b0;
			skip_n  = 1'b0;
			phase_n = PH_NORMAL;
			left_n  = 3'd0;
			acc_n   = 24'd0;
			bad_n   = 1'b0;
			if (!raw_q && phase_q == PH_QUOTE) begin
				bnd.cnt     = CNT_W'(2);
				bnd.item[0] = mk_err(ERR_QUOTE);
				bnd.item[1] = ITEM_END;
			end else if (!raw_q && (phase_q == PH_ESC || phase_q == PH_HEX)) begin
				bnd.cnt     = CNT_W'(2);
				bnd.item[0] = mk_err(ERR_TRUNCATED);
				bnd.item[1] = ITEM_END;
			end else begin
				bnd.cnt     = CNT_W'(1);
				bnd.item[0] = ITEM_END;
			end
		end else if (raw_q) begin
			if (skip_q) begin
				skip_n = 1'b0;
			end else begin
				bnd.cnt     = CNT_W'(1);
				bnd.item[0] = mk_data(in_byte);
			end
		end else begin
			case (phase_q)
				PH_QUOTE: begin
					phase_n = PH_NORMAL;
					if (in_byte == quote_q) begin
						bnd.cnt     = CNT_W'(1);
						bnd.item[0] = mk_data(in_byte);
					end else if (in_byte == CH_BSL) begin
						phase_n     = PH_ESC;
						bnd.cnt     = CNT_W'(1);
						bnd.item[0] = mk_err(ERR_QUOTE);
					end else begin
						bnd.cnt     = CNT_W'(2);
						bnd.item[0] = mk_err(ERR_QUOTE);
						bnd.item[1] = mk_data(in_byte);
					end
				end
				PH_ESC: begin
					phase_n = PH_NORMAL;
					bnd.cnt = CNT_W'(1);
					case (in_byte)
						CH_N: bnd.item[0] = mk_data(BYTE_LF);
						CH_R: bnd.item[0] = mk_data(BYTE_CR);
						CH_T: bnd.item[0] = mk_data(BYTE_TAB);
						CH_B: bnd.item[0] = mk_data(BYTE_BS);
						CH_F: bnd.item[0] = mk_data(BYTE_FF);
						CH_DQ, CH_SQ, CH_BQ, CH_BSL: bnd.item[0] = mk_data(in_byte);
						CH_LU, CH_UU: begin
							bnd.cnt = CNT_W'(0);
							phase_n = PH_HEX;
							left_n  = (in_byte == CH_LU) ? 3'd4 : 3'd6;
							acc_n   = 24'd0;
							bad_n   = 1'b0;
						end
						default: bnd.item[0] = mk_err(ERR_ESCAPE);
					endcase
				end
				PH_HEX: begin
					if (left_dec == 3'd0) begin
						phase_n = PH_NORMAL;
						left_n  = 3'd0;
						acc_n   = 24'd0;
						bad_n   = 1'b0;
						if (bad_upd) begin
							bnd.cnt     = CNT_W'(1);
							bnd.item[0] = mk_err(ERR_HEX);
						end else if (acc_shift > CP_MAX) begin
							bnd.cnt     = CNT_W'(1);
							bnd.item[0] = mk_err(ERR_RANGE);
						end else begin
							bnd = utf8_encode(acc_shift[20:0]);
						end
					end else begin
						left_n = left_dec;
						acc_n  = acc_shift;
						bad_n  = bad_upd;
					end
				end
				default: begin
					phase_n = PH_NORMAL;
					if (in_byte == quote_q) begin
						phase_n = PH_QUOTE;
					end else if (in_byte == CH_BSL) begin
						phase_n = PH_ESC;
					end else begin
						bnd.cnt     = CNT_W'(1);
						bnd.item[0] = mk_data(in_byte);
					end
				end
			endcase
		end
	end

	// Advance the parser state on each accepted byte
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			quote_q <= 8'h00;
			raw_q   <= 1'b0;
			skip_q  <= 1'b0;
			phase_q <= PH_NORMAL;
			left_q  <= 3'd0;
			acc_q   <= 24'd0;
			bad_q   <= 1'b0;
		end else if (accept) begin
			quote_q <= quote_n;
			raw_q   <= raw_n;
			skip_q  <= skip_n;
			phase_q <= phase_n;
			left_q  <= left_n;
			acc_q   <= acc_n;
			bad_q   <= bad_n;
		end
	end

endmodule

FILE: src/qlu_queue.sv
`timescale 1ns / 1ps

module qlu_queue #(
	parameter int DEPTH = 4
) (
	input  logic                 clk,
	input  logic                 arst_n,
	input  logic                 wr_en,
	input  qlu_pkg::qlu_bundle_t wr_data,
	output logic                 q_full,
	input  logic                 rd_en,
	output qlu_pkg::qlu_bundle_t rd_data,
	output logic                 q_empty
);
	import qlu_pkg::*;

	localparam int PTR_W = $clog2(DEPTH);
	localparam int QCNT_W = $clog2(DEPTH + 1);

	qlu_bundle_t       mem_q [DEPTH];
	logic [PTR_W-1:0]  wr_ptr_q;
	logic [PTR_W-1:0]  rd_ptr_q;
	logic [QCNT_W-1:0] cnt_q;

	assign q_full  = (cnt_q == QCNT_W'(DEPTH));
	assign q_empty = (cnt_q == QCNT_W'(0));
	assign rd_data = mem_q[rd_ptr_q];

	// Hold the request bundles
	always_ff @(posedge clk) begin
		if (wr_en) begin
			mem_q[wr_ptr_q] <= wr_data;
		end
	end

	// Advance pointers and track the fill level
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wr_ptr_q <= '0;
			rd_ptr_q <= '0;
			cnt_q    <= '0;
		end else begin
			if (wr_en) begin
				wr_ptr_q <= (wr_ptr_q == PTR_W'(DEPTH - 1)) ? '0 : wr_ptr_q + PTR_W'(1);
			end
			if (rd_en) begin
				rd_ptr_q <= (rd_ptr_q == PTR_W'(DEPTH - 1)) ? '0 : rd_ptr_q + PTR_W'(1);
			end
			if (wr_en && !rd_en) begin
				cnt_q <= cnt_q + QCNT_W'(1);
			end else if (rd_en && !wr_en) begin
				cnt_q <= cnt_q - QCNT_W'(1);
			end
		end
	end

	a_cnt_range: assert property (@(posedge clk) disable iff (!arst_n)
		cnt_q <= QCNT_W'(DEPTH))
		else $error("queue fill level out of range");

	a_no_write_full: assert property (@(posedge clk) disable iff (!arst_n)
		q_full |-> !wr_en)
		else $error("write into a full queue");

	a_no_read_empty: assert property (@(posedge clk) disable iff (!arst_n)
		rd_en |-> !q_empty)
		else $error("read from an empty queue");

	a_no_empty_bundle: assert property (@(posedge clk) disable iff (!arst_n)
		wr_en |-> (wr_data.cnt != CNT_W'(0)))
		else $error("bundle without results written");

endmodule

FILE: src/qlu_back.sv
`timescale 1ns / 1ps

module qlu_back (
	input  logic                 clk,
	input  logic                 arst_n,
	input  qlu_pkg::qlu_bundle_t head,
	input  logic                 q_empty,
	output logic                 rd_en,
	input  logic                 pop,
	output logic                 empty,
	output logic [7:0]           out_byte,
	output logic                 byte_valid,
	output logic                 run_last,
	output logic                 string_end,
	output logic [2:0]           error_code
);
	import qlu_pkg::*;

	logic [IDX_W-1:0] idx_q;
	logic             vld_q;
	qlu_item_t        out_q;
	logic             last_q;
	logic             load;
	logic             is_last;
	logic [CNT_W-1:0] last_idx;

	assign last_idx = head.cnt - CNT_W'(1);
	assign is_last  = (CNT_W'(idx_q) == last_idx);
	assign load     = !q_empty && (!vld_q || pop);
	assign rd_en    = load && is_last;

	// Step through the head bundle one result per cycle while results are taken
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			idx_q <= '0;
			vld_q <= 1'b0;
		end else begin
			if (load) begin
				vld_q <= 1'b1;
				idx_q <= is_last ? '0 : idx_q + IDX_W'(1);
			end else if (pop) begin
				vld_q <= 1'b0;
			end
		end
	end

	// Hold the presented result until it is taken
	always_ff @(posedge clk) begin
		if (load) begin
			out_q  <= head.item[idx_q];
			last_q <= is_last;
		end
	end

	assign empty      = !vld_q;
	assign out_byte   = out_q.data;
	assign byte_valid = out_q.valid;
	assign run_last   = last_q;
	assign string_end = out_q.fin;
	assign error_code = out_q.err;

endmodule
